FILE: rtl/core/xrg_pkg.sv
// Shared types and constants for the xorshift range generator.
package xrg_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [63:0] seed_t;

  localparam mode_t MODE_16 = 2'd0;
  localparam mode_t MODE_32 = 2'd1;
  localparam mode_t MODE_64 = 2'd2;

  localparam mode_t WIDTH_MODE_RST = MODE_32;

  localparam logic ACTION_DRAW = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  // Register index of width_mode on the APB port.
  localparam logic REG_WIDTH_MODE = 1'b0;

  // Shift amounts per xorshift width.
  localparam int S16_A = 7;
  localparam int S16_B = 9;
  localparam int S16_C = 8;
  localparam int S32_A = 13;
  localparam int S32_B = 17;
  localparam int S32_C = 5;
  localparam int S64_A = 13;
  localparam int S64_B = 7;
  localparam int S64_C = 17;

  localparam int DRAW_W = 16;
  localparam int SPAN_W = 32;

endpackage

FILE: rtl/core/xrg_step.sv
// One xorshift step of the seed at the width chosen by the mode.
module xrg_step (
  input  xrg_pkg::seed_t seed,
  input  xrg_pkg::mode_t mode,
  output xrg_pkg::seed_t seed_nxt
);

  logic [15:0] s16_a, s16_b, s16_c;
  logic [31:0] s32_a, s32_b, s32_c;
  logic [63:0] s64_a, s64_b, s64_c;

  always_comb begin
    s16_a = seed[15:0] ^ (seed[15:0] << xrg_pkg::S16_A);
    s16_b = s16_a ^ (s16_a >> xrg_pkg::S16_B);
    s16_c = s16_b ^ (s16_b << xrg_pkg::S16_C);

    s32_a = seed[31:0] ^ (seed[31:0] << xrg_pkg::S32_A);
    s32_b = s32_a ^ (s32_a >> xrg_pkg::S32_B);
    s32_c = s32_b ^ (s32_b << xrg_pkg::S32_C);

    s64_a = seed ^ (seed << xrg_pkg::S64_A);
    s64_b = s64_a ^ (s64_a >> xrg_pkg::S64_B);
    s64_c = s64_b ^ (s64_b << xrg_pkg::S64_C);
  end

  // Unused mode code falls back to the 64-bit step.
  always_comb begin
    unique case (mode)
      xrg_pkg::MODE_16: seed_nxt = {48'd0, s16_c};
      xrg_pkg::MODE_32: seed_nxt = {32'd0, s32_c};
      default:          seed_nxt = s64_c;
    endcase
  end

endmodule

FILE: rtl/core/xrg_rem.sv
// Restoring remainder unit: 16-bit dividend by a 32-bit divisor, one bit a cycle.
module xrg_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [xrg_pkg::DRAW_W-1:0]   dividend,
  input  logic [xrg_pkg::SPAN_W-1:0]   divisor,
  output logic                         done,
  output logic [xrg_pkg::DRAW_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(xrg_pkg::DRAW_W + 1);

  logic [xrg_pkg::DRAW_W-1:0] rem_r, rem_nxt;
  logic [xrg_pkg::DRAW_W-1:0] dvd_r, dvd_nxt;
  logic [xrg_pkg::SPAN_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [xrg_pkg::DRAW_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[xrg_pkg::DRAW_W-1]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(xrg_pkg::DRAW_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Subtract when the shifted partial remainder reaches the divisor.
      if ({{(xrg_pkg::SPAN_W-xrg_pkg::DRAW_W-1){1'b0}}, trial} >= dvs_r) begin
        rem_nxt = xrg_pkg::DRAW_W'(({{(xrg_pkg::SPAN_W-xrg_pkg::DRAW_W-1){1'b0}}, trial})
                                   - dvs_r);
      end else begin
        rem_nxt = trial[xrg_pkg::DRAW_W-1:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/core/xorshift_range_generator.sv
// Top level: seed register, sequencer, remainder unit, clamp and output register.
//
// The block keeps a 64-bit seed. An input item either loads the seed
// (action = 1) or draws a number in [in_range_low, in_range_high] (action = 0).
// Input and result channels use valid/stall; a transfer happens at a clock
// edge with valid high and stall low. Every item gives exactly one result.
// A load writes the seed at the transfer, then registers its result in
// ST_FIN. A draw steps the seed, forms the span and starts the remainder
// unit in ST_STEP, waits in ST_DIV while the restoring remainder unit works
// (one quotient bit a cycle) until its done flag, then adds the low bound,
// clamps and registers in ST_FIN. No new item enters until the last one's
// result is registered; the input reopens as out_valid rises.
// in_stall is high from the transfer until the result is written into the
// output register; the output register lets the next item enter while a
// finished result still waits. If out_stall holds the output register, a
// finished result waits in the last step until the register frees.
// Synchronous reset (rst_n low) clears the seed to 0, sets width_mode to
// the 32-bit step and empties the output register.
// width_mode sits at APB byte address 0; write it only while idle.
module xorshift_range_generator (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_seed_value,
  input  logic signed [31:0] in_range_low,
  input  logic signed [31:0] in_range_high,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [15:0] out_raw_draw,
  output logic [63:0] out_seed_after,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  xrg_pkg::mode_t        mode_r, mode_nxt;
  xrg_pkg::seed_t        seed_r, seed_nxt;
  logic                  load_r, load_nxt;
  logic signed [31:0]    lo_r, lo_nxt;
  logic signed [31:0]    hi_r, hi_nxt;
  logic [15:0]           raw_r, raw_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [31:0]    out_value_r, out_value_nxt;
  logic [15:0]           out_raw_r, out_raw_nxt;
  logic [63:0]           out_seed_r, out_seed_nxt;

  xrg_pkg::seed_t        step_seed;
  logic                  rem_start;
  logic                  rem_done;
  logic [15:0]           rem_val;
  logic signed [32:0]    span;
  logic [32:0]           span_abs;
  logic [31:0]           span_mag;
  logic signed [33:0]    sum;
  logic signed [31:0]    clamped;
  logic                  in_xfer;
  logic                  fin_go;
  logic                  cfg_wr;
  xrg_pkg::seed_t        load_seed;

  xrg_step u_step (
    .seed     (seed_r),
    .mode     (mode_r),
    .seed_nxt (step_seed)
  );

  xrg_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (step_seed[15:0]),
    .divisor   (span_mag),
    .done      (rem_done),
    .remainder (rem_val)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign rem_start = (state_r == ST_STEP);
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign cfg_wr    = psel && penable && pwrite && pready;

  // Span magnitude; a zero span counts as one.
  always_comb begin
    span     = 33'(hi_r) - 33'(lo_r);
    span_abs = span[32] ? 33'(-span) : 33'(span);
    span_mag = (span_abs == 33'd0) ? 32'd1 : span_abs[31:0];
  end

  // Offset and clamp, upper bound first.
  always_comb begin
    sum = 34'(lo_r) + $signed({18'd0, rem_val});
    priority if (sum > 34'(hi_r)) begin
      clamped = hi_r;
    end else if (sum < 34'(lo_r)) begin
      clamped = lo_r;
    end else begin
      clamped = sum[31:0];
    end
  end

  always_comb begin
    unique case (mode_r)
      xrg_pkg::MODE_16: load_seed = {48'd0, in_seed_value[15:0]};
      xrg_pkg::MODE_32: load_seed = {32'd0, in_seed_value[31:0]};
      default:          load_seed = in_seed_value;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    load_nxt      = load_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    raw_nxt       = raw_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_raw_nxt   = out_raw_r;
    out_seed_nxt  = out_seed_r;
    mode_nxt      = mode_r;

    if (cfg_wr && (paddr[2] == xrg_pkg::REG_WIDTH_MODE)) begin
      mode_nxt = pwdata[1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          load_nxt = (in_action == xrg_pkg::ACTION_LOAD);
          lo_nxt   = in_range_low;
          hi_nxt   = in_range_high;
          if (in_action == xrg_pkg::ACTION_LOAD) begin
            seed_nxt  = load_seed;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        seed_nxt  = step_seed;
        raw_nxt   = step_seed[15:0];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold here until the output register frees.
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = load_r ? 32'sd0 : clamped;
          out_raw_nxt   = load_r ? 16'd0 : raw_r;
          out_seed_nxt  = seed_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= xrg_pkg::WIDTH_MODE_RST;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
      load_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
      load_r      <= load_nxt;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    raw_r       <= raw_nxt;
    out_value_r <= out_value_nxt;
    out_raw_r   <= out_raw_nxt;
    out_seed_r  <= out_seed_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_raw_draw   = out_raw_r;
  assign out_seed_after = out_seed_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == xrg_pkg::REG_WIDTH_MODE) ? {30'd0, mode_r} : 32'd0;

endmodule

FILE: rtl/core/xrg_chk.sv
// Port-level checker for the xorshift range generator, bound to the top level.
module xrg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value,
  input logic [15:0] out_raw_draw,
  input logic [63:0] out_seed_after,
  input logic        psel,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] prdata
);

  // One item at a time: a transfer closes the input until its result is done.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // A rising out_valid comes with the sequencer reopening the input.
  a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $fell(in_stall))
    else $error("result appeared without the input reopening");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(out_raw_draw) && $stable(out_seed_after))
    else $error("stalled result changed");

  // The mode register reads back within its two bits.
  a_mode_read: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite && paddr == 3'd0 |-> prdata[31:2] == 30'd0)
    else $error("mode readback has stray bits");

endmodule

bind xorshift_range_generator xrg_chk u_xrg_chk (.*);
